// ===== hw/rtl/tnc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k nearest collector package
// Shared types and fixed constants of the collector and its sub-blocks.
// ----------------------------------------------------------------------------
package tnc_pkg;

   localparam int KEEP_BITS  = 7;
   localparam int KEEP_LIMIT = 64;
   localparam int KEEP_RESET = 8;

   localparam logic       ACTION_INSERT  = 1'b0;
   localparam logic       ACTION_DRAIN   = 1'b1;
   localparam logic       KIND_STATUS    = 1'b0;
   localparam logic       KIND_ENTRY     = 1'b1;
   localparam logic       REG_KEEP_COUNT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_STATUS,
      ST_EMPTY
   } state_type;

   typedef enum logic {
      SCAN_MAX,
      SCAN_MIN
   } scan_mode_type;

   typedef struct packed {
      logic          clear;
      logic          sample;
      scan_mode_type mode;
   } scan_cmd_type;

endpackage
`default_nettype wire

// ===== hw/rtl/tnc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Candidate store
// One write port and one registered read port over the held ids and distances.
// ----------------------------------------------------------------------------
module tnc_store #(
   parameter int DEPTH     = 64,
   parameter int AW        = 6,
   parameter int ID_BITS   = 32,
   parameter int DIST_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AW-1:0]        wr_addr,
   input  wire logic [ID_BITS-1:0]   wr_id,
   input  wire logic [DIST_BITS-1:0] wr_dist,
   input  wire logic [AW-1:0]        rd_addr,
   output logic      [ID_BITS-1:0]   rd_id,
   output logic      [DIST_BITS-1:0] rd_dist
);

   logic [ID_BITS-1:0]   id_mem   [DEPTH];
   logic [DIST_BITS-1:0] dist_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]   <= wr_id;
         dist_mem[wr_addr] <= wr_dist;
      end
      rd_id   <= id_mem[rd_addr];
      rd_dist <= dist_mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/tnc_best_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Shared compare unit
// Tracks the largest or the smallest distance over a stream of samples,
// keeping the first slot on ties.
// ----------------------------------------------------------------------------
module tnc_best_unit #(
   parameter int AW        = 6,
   parameter int ID_BITS   = 32,
   parameter int DIST_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tnc_pkg::scan_cmd_type cmd,
   input  wire logic [AW-1:0]         smp_slot,
   input  wire logic [ID_BITS-1:0]    smp_id,
   input  wire logic [DIST_BITS-1:0]  smp_dist,
   output logic      [AW-1:0]         best_slot,
   output logic      [ID_BITS-1:0]    best_id,
   output logic      [DIST_BITS-1:0]  best_dist
);
   import tnc_pkg::*;

   logic                 found_ff;
   logic                 found_in;
   logic [AW-1:0]        slot_ff;
   logic [AW-1:0]        slot_in;
   logic [ID_BITS-1:0]   id_ff;
   logic [ID_BITS-1:0]   id_in;
   logic [DIST_BITS-1:0] dist_ff;
   logic [DIST_BITS-1:0] dist_in;
   logic                 better;

   always_comb begin
      if (cmd.mode == SCAN_MAX) begin
         better = smp_dist > dist_ff;
      end else begin
         better = smp_dist < dist_ff;
      end
      found_in = found_ff;
      slot_in  = slot_ff;
      id_in    = id_ff;
      dist_in  = dist_ff;
      if (cmd.clear) begin
         found_in = 1'b0;
      end else if (cmd.sample && (!found_ff || better)) begin
         found_in = 1'b1;
         slot_in  = smp_slot;
         id_in    = smp_id;
         dist_in  = smp_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      slot_ff <= slot_in;
      id_ff   <= id_in;
      dist_ff <= dist_in;
   end

   assign best_slot = slot_ff;
   assign best_id   = id_ff;
   assign best_dist = dist_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/topk_nearest_collector_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Top-k nearest collector
// Keeps the keep_count nearest (id, distance) candidates and drains them sorted.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; req_tready is high only while idle.
// An insert that leaves the store not full goes straight to its status
// response; an insert that fills the store or replaces its worst entry
// rescans the store through the single read port of the candidate memory.
// A drain runs one scan over the store per emitted entry, and an output stall
// holds it. There is no clearing pass after reset.
module topk_nearest_collector_core #(
   parameter int MAX_KEEP  = 64,
   parameter int DIST_BITS = 32,
   parameter int ID_BITS   = 32
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   // Fields from bit 0: cand_id, cand_distance.
   input  wire logic [((ID_BITS+DIST_BITS+7)/8)*8-1:0]      req_tdata,
   // Fields from bit 0: action.
   input  wire logic                                        req_tuser,
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // Fields from bit 0: out_id, out_distance, worst_distance, free_slots.
   output logic [((ID_BITS+2*DIST_BITS+tnc_pkg::KEEP_BITS+7)/8)*8-1:0] rsp_tdata,
   // Fields from bit 0: out_kind, empty_res.
   output logic [1:0]                                       rsp_tuser,
   output logic                                             rsp_tlast,
   input  wire logic                                        csr_psel,
   input  wire logic                                        csr_penable,
   input  wire logic                                        csr_pwrite,
   input  wire logic [2:0]                                  csr_paddr,
   input  wire logic [31:0]                                 csr_pwdata,
   output logic [31:0]                                      csr_prdata,
   output logic                                             csr_pready
);
   import tnc_pkg::*;

   localparam int DEPTH     = (MAX_KEEP < KEEP_LIMIT) ? MAX_KEEP : KEEP_LIMIT;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KEEP_INIT = (DEPTH < KEEP_RESET) ? DEPTH : KEEP_RESET;
   localparam int RSP_W     = ID_BITS + 2 * DIST_BITS + KEEP_BITS;
   localparam int RSP_PAD   = ((RSP_W + 7) / 8) * 8;

   state_type             state_ff;
   state_type             state_in;
   logic [KEEP_BITS-1:0]  keep_ff;
   logic [KEEP_BITS-1:0]  keep_in;
   logic [KEEP_BITS-1:0]  fill_ff;
   logic [KEEP_BITS-1:0]  fill_in;
   logic [KEEP_BITS-1:0]  cnt_ff;
   logic [KEEP_BITS-1:0]  cnt_in;
   logic [KEEP_BITS-1:0]  k_ff;
   logic [KEEP_BITS-1:0]  k_in;
   logic                  pend_ff;
   logic                  pend_in;
   logic [AW-1:0]         pend_slot_ff;
   logic [AW-1:0]         pend_slot_in;
   scan_mode_type         mode_ff;
   scan_mode_type         mode_in;
   logic [DEPTH-1:0]      used_ff;
   logic [DEPTH-1:0]      used_in;
   logic [DIST_BITS-1:0]  worst_dist_ff;
   logic [DIST_BITS-1:0]  worst_dist_in;
   logic [AW-1:0]         worst_slot_ff;
   logic [AW-1:0]         worst_slot_in;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_kind_ff;
   logic                  rsp_kind_in;
   logic                  rsp_empty_ff;
   logic                  rsp_empty_in;
   logic                  rsp_last_ff;
   logic                  rsp_last_in;
   logic [ID_BITS-1:0]    rsp_id_ff;
   logic [ID_BITS-1:0]    rsp_id_in;
   logic [DIST_BITS-1:0]  rsp_dist_ff;
   logic [DIST_BITS-1:0]  rsp_dist_in;
   logic [DIST_BITS-1:0]  rsp_worst_ff;
   logic [DIST_BITS-1:0]  rsp_worst_in;
   logic [KEEP_BITS-1:0]  rsp_free_ff;
   logic [KEEP_BITS-1:0]  rsp_free_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic [ID_BITS-1:0]    rd_id;
   logic [DIST_BITS-1:0]  rd_dist;
   scan_cmd_type          cmd;
   logic [AW-1:0]         best_slot;
   logic [ID_BITS-1:0]    best_id;
   logic [DIST_BITS-1:0]  best_dist;

   logic [ID_BITS-1:0]    cand_id;
   logic [DIST_BITS-1:0]  cand_dist;
   logic                  req_fire;
   logic                  csr_wr;
   logic                  out_free;
   logic                  is_full;
   logic [KEEP_BITS-1:0]  keep_wr;
   logic [DIST_BITS-1:0]  worst_now;
   logic                  last_entry;

   assign cand_id   = req_tdata[ID_BITS-1:0];
   assign cand_dist = req_tdata[ID_BITS +: DIST_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign is_full    = fill_ff >= keep_ff;
   assign worst_now  = is_full ? worst_dist_ff : {DIST_BITS{1'b1}};
   assign last_entry = (k_ff + KEEP_BITS'(1)) == fill_ff;

   always_comb begin
      if (csr_pwdata[KEEP_BITS-1:0] == '0) begin
         keep_wr = KEEP_BITS'(1);
      end else if (csr_pwdata[KEEP_BITS-1:0] > KEEP_BITS'(DEPTH)) begin
         keep_wr = KEEP_BITS'(DEPTH);
      end else begin
         keep_wr = csr_pwdata[KEEP_BITS-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      keep_in       = keep_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      pend_in       = pend_ff;
      pend_slot_in  = pend_slot_ff;
      mode_in       = mode_ff;
      used_in       = used_ff;
      worst_dist_in = worst_dist_ff;
      worst_slot_in = worst_slot_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[AW-1:0];
      rd_addr       = cnt_ff[AW-1:0];
      cmd.clear     = 1'b0;
      cmd.mode      = mode_ff;
      cmd.sample    = pend_ff && ((mode_ff == SCAN_MAX) || !used_ff[pend_slot_ff]);

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_dist_in   = rsp_dist_ff;
      rsp_worst_in  = rsp_worst_ff;
      rsp_free_in   = rsp_free_ff;

      if (csr_wr && (csr_paddr[2] == REG_KEEP_COUNT)) begin
         keep_in = keep_wr;
         fill_in = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == ACTION_INSERT) begin
                  if (!is_full) begin
                     wr_en   = 1'b1;
                     wr_addr = fill_ff[AW-1:0];
                     fill_in = fill_ff + KEEP_BITS'(1);
                     if ((fill_ff + KEEP_BITS'(1)) == keep_ff) begin
                        state_in  = ST_SCAN;
                        mode_in   = SCAN_MAX;
                        cmd.clear = 1'b1;
                        cnt_in    = '0;
                     end else begin
                        state_in = ST_STATUS;
                     end
                  end else if (cand_dist < worst_dist_ff) begin
                     wr_en     = 1'b1;
                     wr_addr   = worst_slot_ff;
                     state_in  = ST_SCAN;
                     mode_in   = SCAN_MAX;
                     cmd.clear = 1'b1;
                     cnt_in    = '0;
                  end else begin
                     state_in = ST_STATUS;
                  end
               end else if (fill_ff == '0) begin
                  state_in = ST_EMPTY;
               end else begin
                  used_in   = '0;
                  k_in      = '0;
                  state_in  = ST_SCAN;
                  mode_in   = SCAN_MIN;
                  cmd.clear = 1'b1;
                  cnt_in    = '0;
               end
            end
         end
         ST_SCAN: begin
            if (cnt_ff < fill_ff) begin
               rd_addr      = cnt_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_slot_in = cnt_ff[AW-1:0];
               cnt_in       = cnt_ff + KEEP_BITS'(1);
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  if (mode_ff == SCAN_MAX) begin
                     worst_dist_in = best_dist;
                     worst_slot_in = best_slot;
                     state_in      = ST_STATUS;
                  end else begin
                     state_in = ST_EMIT;
                  end
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_kind_in           = KIND_ENTRY;
               rsp_empty_in          = 1'b0;
               rsp_last_in           = last_entry;
               rsp_id_in             = best_id;
               rsp_dist_in           = best_dist;
               rsp_worst_in          = worst_now;
               rsp_free_in           = keep_ff - fill_ff;
               used_in[best_slot]    = 1'b1;
               k_in                  = k_ff + KEEP_BITS'(1);
               if (last_entry) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in  = ST_SCAN;
                  cmd.clear = 1'b1;
                  cnt_in    = '0;
               end
            end
         end
         ST_STATUS, ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = (state_ff == ST_EMPTY) ? KIND_ENTRY : KIND_STATUS;
               rsp_empty_in = (state_ff == ST_EMPTY);
               rsp_last_in  = 1'b1;
               rsp_id_in    = '0;
               rsp_dist_in  = '0;
               rsp_worst_in = worst_now;
               rsp_free_in  = keep_ff - fill_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keep_ff      <= KEEP_BITS'(KEEP_INIT);
         fill_ff      <= '0;
         cnt_ff       <= '0;
         k_ff         <= '0;
         pend_ff      <= 1'b0;
         mode_ff      <= SCAN_MAX;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         keep_ff      <= keep_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         pend_ff      <= pend_in;
         mode_ff      <= mode_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pend_slot_ff  <= pend_slot_in;
      worst_dist_ff <= worst_dist_in;
      worst_slot_ff <= worst_slot_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_dist_ff   <= rsp_dist_in;
      rsp_worst_ff  <= rsp_worst_in;
      rsp_free_ff   <= rsp_free_in;
   end

   tnc_store #(
      .DEPTH     (DEPTH),
      .AW        (AW),
      .ID_BITS   (ID_BITS),
      .DIST_BITS (DIST_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_id   (cand_id),
      .wr_dist (cand_dist),
      .rd_addr (rd_addr),
      .rd_id   (rd_id),
      .rd_dist (rd_dist)
   );

   tnc_best_unit #(
      .AW        (AW),
      .ID_BITS   (ID_BITS),
      .DIST_BITS (DIST_BITS)
   ) u_best (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .smp_slot  (pend_slot_ff),
      .smp_id    (rd_id),
      .smp_dist  (rd_dist),
      .best_slot (best_slot),
      .best_id   (best_id),
      .best_dist (best_dist)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_empty_ff, rsp_kind_ff};
   assign rsp_tdata  = RSP_PAD'({rsp_free_ff, rsp_worst_ff, rsp_dist_ff, rsp_id_ff});

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_KEEP_COUNT) ? 32'(keep_ff) : '0;

endmodule
`default_nettype wire
